/* rtl/tgd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgd_pkg
// Shared constants and types of the turning grille decryptor.
// ----------------------------------------------------------------------------
package tgd_pkg;

	localparam int MAX_SIZE        = 8;
	localparam int CELLS           = MAX_SIZE * MAX_SIZE;
	localparam int ADDR_W          = $clog2(CELLS);
	localparam int COUNT_W         = $clog2(CELLS + 1);
	localparam int COORD_W         = $clog2(MAX_SIZE);
	localparam int GRID_W          = 4;
	localparam int BYTE_W          = 8;
	localparam int TURN_W          = 2;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(4);

	localparam logic ACT_CELL   = 1'b0;
	localparam logic ACT_CIPHER = 1'b1;

	typedef struct packed {
		logic              is_cipher;
		logic              hole;
		logic [BYTE_W-1:0] data;
		logic [ADDR_W-1:0] addr;
		logic              decode;
		logic [GRID_W-1:0] side;
	} cmd_t;

endpackage

/* rtl/tgd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgd_feed_if / tgd_result_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface tgd_feed_if;
	import tgd_pkg::*;

	logic              valid;
	logic              ready;
	logic              action;
	logic              hole;
	logic [BYTE_W-1:0] cipher_byte;

	modport source (output valid, output action, output hole, output cipher_byte, input ready);
	modport sink (input valid, input action, input hole, input cipher_byte, output ready);
endinterface

interface tgd_result_if;
	import tgd_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] plain_byte;
	logic              last;
	logic              invalid;

	modport source (output valid, output plain_byte, output last, output invalid, input ready);
	modport sink (input valid, input plain_byte, input last, input invalid, output ready);
endinterface

/* rtl/tgd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgd_front
// Accepts input words, holds the grid size, tracks cell and byte counts and
// turns each word into a store command for the back end.
// ----------------------------------------------------------------------------
module tgd_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [tgd_pkg::GRID_W-1:0] cfg_data,
	tgd_feed_if.sink                   feed,
	output tgd_pkg::cmd_t              cmd,
	output logic                       cmd_valid,
	input  logic                       cmd_ready
);
	import tgd_pkg::*;

	logic [GRID_W-1:0]  grid_q;
	logic [GRID_W-1:0]  side;
	logic [COUNT_W-1:0] cell_cnt_q;
	logic [COUNT_W-1:0] byte_cnt_q;
	logic [COUNT_W-1:0] area;
	logic [COUNT_W-1:0] cell_idx;
	logic [COUNT_W-1:0] byte_idx;
	logic [COUNT_W-1:0] byte_next;
	logic               is_cipher;
	logic               take;

	always_comb begin
		if (grid_q == '0) begin
			side = GRID_W'(1);
		end else if (grid_q > GRID_W'(MAX_SIZE)) begin
			side = GRID_W'(MAX_SIZE);
		end else begin
			side = grid_q;
		end
	end

	assign area      = COUNT_W'(side) * COUNT_W'(side);
	assign cell_idx  = (cell_cnt_q >= area) ? '0 : cell_cnt_q;
	assign byte_idx  = (byte_cnt_q >= area) ? '0 : byte_cnt_q;
	assign byte_next = byte_idx + 1'b1;
	assign is_cipher = (feed.action == ACT_CIPHER);

	always_comb begin
		cmd.is_cipher = is_cipher;
		cmd.hole      = feed.hole;
		cmd.data      = feed.cipher_byte;
		cmd.addr      = is_cipher ? ADDR_W'(byte_idx) : ADDR_W'(cell_idx);
		cmd.decode    = is_cipher && (byte_next == area);
		cmd.side      = side;
	end

	assign cmd_valid  = feed.valid;
	assign feed.ready = cmd_ready;
	assign take       = feed.valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q     <= GRID_RESET;
			cell_cnt_q <= '0;
			byte_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				grid_q <= cfg_data;
			end
			if (take) begin
				if (is_cipher) begin
					byte_cnt_q <= cmd.decode ? '0 : byte_next;
				end else begin
					cell_cnt_q <= cell_idx + 1'b1;
					byte_cnt_q <= '0;
				end
			end
		end
	end

endmodule

/* rtl/tgd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgd_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tgd_queue #(
	parameter int DEPTH = tgd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tgd_pkg::cmd_t push_cmd,
	input  logic          push_valid,
	output logic          push_ready,
	output tgd_pkg::cmd_t pop_cmd,
	output logic          pop_valid,
	input  logic          pop_ready
);
	import tgd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/tgd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgd_back
// Stores mask cells and ciphertext, scans the four grille orientations
// through a three-stage memory pipeline, checks coverage and streams out
// the plaintext or a single invalid word.
// ----------------------------------------------------------------------------
module tgd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  tgd_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	tgd_result_if.source  result
);
	import tgd_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_DRAIN = 6'b000100,
		S_ERR   = 6'b001000,
		S_EMIT  = 6'b010000,
		S_FLUSH = 6'b100000
	} state_t;

	state_t             state_q;
	logic [GRID_W-1:0]  side_q;
	logic [COUNT_W-1:0] area_q;
	logic [COORD_W-1:0] nm1;
	logic [TURN_W-1:0]  turn_q;
	logic [COORD_W-1:0] row_q;
	logic [COORD_W-1:0] col_q;
	logic [ADDR_W-1:0]  dest_q;
	logic [COORD_W-1:0] src_row;
	logic [COORD_W-1:0] src_col;
	logic [ADDR_W-1:0]  src_addr;
	logic               row_end;
	logic               col_end;

	logic               hole_mem   [CELLS];
	logic [BYTE_W-1:0]  cipher_mem [CELLS];
	logic [BYTE_W-1:0]  plain_mem  [CELLS];

	logic               pop;
	logic               start;
	logic               hole_re;
	logic               hv_s1;
	logic               hole_rd_s1;
	logic [ADDR_W-1:0]  dest_s1;
	logic               take_hole;
	logic               overrun;
	logic               cipher_re;
	logic               cv_s2;
	logic [BYTE_W-1:0]  cipher_rd_s2;
	logic [ADDR_W-1:0]  dest_s2;
	logic [COUNT_W-1:0] used_q;
	logic               bad_q;
	logic [CELLS-1:0]   covered_q;
	logic [COUNT_W-1:0] cover_cnt_q;

	logic [ADDR_W-1:0]  emit_idx_q;
	logic               emit_last;
	logic               plain_re;
	logic               pv_s1;
	logic [BYTE_W-1:0]  plain_rd_s1;
	logic               plast_s1;
	logic               out_free;
	logic               move;
	logic               err_load;
	logic               out_v_q;
	logic [BYTE_W-1:0]  out_plain_q;
	logic               out_last_q;
	logic               out_invalid_q;

	assign cmd_ready = (state_q == S_IDLE);
	assign pop       = cmd_valid && cmd_ready;
	assign start     = pop && cmd.is_cipher && cmd.decode;

	// orientation scan
	assign nm1     = COORD_W'(side_q - 1'b1);
	assign col_end = (col_q == nm1);
	assign row_end = (row_q == nm1);

	always_comb begin
		case (turn_q)
			2'd0: begin
				src_row = row_q;
				src_col = col_q;
			end
			2'd1: begin
				src_row = nm1 - col_q;
				src_col = row_q;
			end
			2'd2: begin
				src_row = nm1 - row_q;
				src_col = nm1 - col_q;
			end
			default: begin
				src_row = col_q;
				src_col = nm1 - row_q;
			end
		endcase
	end

	assign src_addr = ADDR_W'(src_row) * ADDR_W'(side_q) + ADDR_W'(src_col);
	assign hole_re  = (state_q == S_SCAN);

	// hole lookup and ciphertext fetch
	assign take_hole = hv_s1 && hole_rd_s1 && !bad_q;
	assign overrun   = take_hole && (used_q >= area_q);
	assign cipher_re = take_hole && !overrun;

	always_ff @(posedge clk) begin
		if (pop && !cmd.is_cipher) begin
			hole_mem[cmd.addr] <= cmd.hole;
		end
		if (hole_re) begin
			hole_rd_s1 <= hole_mem[src_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop && cmd.is_cipher) begin
			cipher_mem[cmd.addr] <= cmd.data;
		end
		if (cipher_re) begin
			cipher_rd_s2 <= cipher_mem[ADDR_W'(used_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (cv_s2) begin
			plain_mem[dest_s2] <= cipher_rd_s2;
		end
		if (plain_re) begin
			plain_rd_s1 <= plain_mem[emit_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		dest_s1 <= dest_q;
		dest_s2 <= dest_s1;
		if (plain_re) begin
			plast_s1 <= emit_last;
		end
	end

	// output side
	assign emit_last = ((COUNT_W'(emit_idx_q) + 1'b1) == area_q);
	assign out_free  = !out_v_q || result.ready;
	assign move      = pv_s1 && out_free;
	assign plain_re  = (state_q == S_EMIT) && (!pv_s1 || move);
	assign err_load  = (state_q == S_ERR) && out_free;

	always_ff @(posedge clk) begin
		if (move) begin
			out_plain_q   <= plain_rd_s1;
			out_last_q    <= plast_s1;
			out_invalid_q <= 1'b0;
		end else if (err_load) begin
			out_plain_q   <= '0;
			out_last_q    <= 1'b1;
			out_invalid_q <= 1'b1;
		end
	end

	assign result.valid      = out_v_q;
	assign result.plain_byte = out_plain_q;
	assign result.last       = out_last_q;
	assign result.invalid    = out_invalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			side_q      <= GRID_W'(1);
			area_q      <= COUNT_W'(1);
			turn_q      <= '0;
			row_q       <= '0;
			col_q       <= '0;
			dest_q      <= '0;
			hv_s1       <= 1'b0;
			cv_s2       <= 1'b0;
			used_q      <= '0;
			bad_q       <= 1'b0;
			covered_q   <= '0;
			cover_cnt_q <= '0;
			emit_idx_q  <= '0;
			pv_s1       <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			hv_s1   <= hole_re;
			cv_s2   <= cipher_re;
			pv_s1   <= plain_re || (pv_s1 && !move);
			out_v_q <= move || err_load || (out_v_q && !result.ready);

			if (cipher_re) begin
				used_q <= used_q + 1'b1;
			end
			if (overrun) begin
				bad_q <= 1'b1;
			end
			if (cv_s2) begin
				covered_q[dest_s2] <= 1'b1;
				if (!covered_q[dest_s2]) begin
					cover_cnt_q <= cover_cnt_q + 1'b1;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (start) begin
						side_q      <= cmd.side;
						area_q      <= COUNT_W'(cmd.side) * COUNT_W'(cmd.side);
						turn_q      <= '0;
						row_q       <= '0;
						col_q       <= '0;
						dest_q      <= '0;
						used_q      <= '0;
						bad_q       <= 1'b0;
						covered_q   <= '0;
						cover_cnt_q <= '0;
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (col_end) begin
						col_q <= '0;
						if (row_end) begin
							row_q  <= '0;
							dest_q <= '0;
							turn_q <= turn_q + 1'b1;
							if (turn_q == TURN_W'(3)) begin
								state_q <= S_DRAIN;
							end
						end else begin
							row_q  <= row_q + 1'b1;
							dest_q <= dest_q + 1'b1;
						end
					end else begin
						col_q  <= col_q + 1'b1;
						dest_q <= dest_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (!hv_s1 && !cv_s2) begin
						emit_idx_q <= '0;
						if (bad_q || (cover_cnt_q != area_q)) begin
							state_q <= S_ERR;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_ERR: begin
					if (err_load) begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (plain_re) begin
						emit_idx_q <= emit_idx_q + 1'b1;
						if (emit_last) begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_FLUSH: begin
					if (!pv_s1) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/turning_grille_decrypt_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turning_grille_decrypt_top
// Turning grille decryptor: loads an N by N hole mask and N*N ciphertext
// bytes, then emits the plaintext in row-major order or one invalid word.
// ----------------------------------------------------------------------------
//  port     dir  handshake    word
//  feed     in   valid/ready  action, hole, cipher_byte
//  result   out  valid/ready  plain_byte, last, invalid
//  cfg      in   cfg_we       cfg_data = grid_size
//
//  mask and ciphertext words are taken one per cycle while the command
//  queue has room; each is stored by the back end while it is idle
//  the final ciphertext word starts a scan of all four orientations over the
//  hole memory, followed by pipeline drain and coverage check
//  plaintext leaves at one byte per cycle while result is ready, from the
//  plaintext memory port; an invalid grille gives one word after the check
//  a stall on result holds the back end; the front keeps filling the queue
//  reset needs no clearing pass; memories hold no reset value
// ----------------------------------------------------------------------------
module turning_grille_decrypt_top #(
	parameter int QUEUE_DEPTH = tgd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [tgd_pkg::GRID_W-1:0] cfg_data,
	tgd_feed_if.sink                   feed,
	tgd_result_if.source               result
);
	import tgd_pkg::*;

	cmd_t front_cmd;
	logic front_valid;
	logic front_ready;
	cmd_t back_cmd;
	logic back_valid;
	logic back_ready;

	tgd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.feed      (feed),
		.cmd       (front_cmd),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready)
	);

	tgd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (front_cmd),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_cmd    (back_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	tgd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (back_cmd),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.result    (result)
	);

endmodule

/* rtl/tgd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgd_checker
// Port-level checks of the turning grille decryptor, bound to the top level.
// ----------------------------------------------------------------------------
module tgd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       feed_valid,
	input logic                       feed_ready,
	input logic                       feed_action,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [tgd_pkg::BYTE_W-1:0] res_plain,
	input logic                       res_last,
	input logic                       res_invalid
);
	import tgd_pkg::*;

	logic seen_cipher_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_cipher_q <= 1'b0;
		end else if (feed_valid && feed_ready && (feed_action == ACT_CIPHER)) begin
			seen_cipher_q <= 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_plain) && $stable(res_last)
			&& $stable(res_invalid))
		else $error("result word changed while stalled");

	a_invalid_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_invalid |-> res_last && (res_plain == '0))
		else $error("invalid word not marked last or carries data");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> seen_cipher_q)
		else $error("result word before any ciphertext word");

endmodule

bind turning_grille_decrypt_top tgd_checker u_tgd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.feed_valid  (feed.valid),
	.feed_ready  (feed.ready),
	.feed_action (feed.action),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_plain   (result.plain_byte),
	.res_last    (result.last),
	.res_invalid (result.invalid)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for turning_grille_decrypt_top. A driver feeds mask and
// ciphertext words from a pending queue; a monitor predicts the plaintext or
// rejection of every message from its own grille model and checks each result
// word in order. Phases vary the grid size over 0..15 and the handshake
// idling, including a long receiver hold and a sender pause.
// ----------------------------------------------------------------------------
module testbench;
	import tgd_pkg::*;

	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 300;

	typedef struct packed {
		logic              action;
		logic              hole;
		logic [BYTE_W-1:0] cipher;
	} feed_word_t;

	typedef struct packed {
		logic [BYTE_W-1:0] plain;
		logic              last;
		logic              invalid;
	} plain_word_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [GRID_W-1:0] cfg_data = GRID_RESET;

	logic              drv_valid = 1'b0;
	logic              drv_action = ACT_CELL;
	logic              drv_hole = 1'b0;
	logic [BYTE_W-1:0] drv_cipher = '0;
	logic              rx_ready = 1'b0;

	tgd_feed_if   feed_if ();
	tgd_result_if result_if ();

	assign feed_if.valid       = drv_valid;
	assign feed_if.action      = drv_action;
	assign feed_if.hole        = drv_hole;
	assign feed_if.cipher_byte = drv_cipher;
	assign result_if.ready     = rx_ready;

	turning_grille_decrypt_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.feed    (feed_if),
		.result  (result_if)
	);

	// stimulus and traffic control
	feed_word_t  pend_q[$];
	int unsigned tx_idle_pct = 0;
	int unsigned rx_stall_pct = 0;
	logic        hold_kick = 1'b0;
	logic        hold_seen = 1'b0;
	int unsigned hold_left = 0;

	// prediction state
	logic [GRID_W-1:0] pr_grid = GRID_RESET;
	logic              pr_hole [CELLS];
	logic [BYTE_W-1:0] pr_cipher [CELLS];
	logic [BYTE_W-1:0] pr_plain [CELLS];
	logic              pr_cov [CELLS];
	int unsigned       pr_cells = 0;
	int unsigned       pr_bytes = 0;
	plain_word_t       plain_expect_q[$];

	// generator mirror of the write pointers
	int unsigned gen_n = 4;
	int unsigned gen_cells = 0;
	int unsigned gen_bytes = 0;
	int unsigned gen_items = 0;
	logic        gen_written [CELLS];
	logic        gen_grille [CELLS];

	int unsigned words_in = 0;
	int unsigned words_out = 0;
	int unsigned plain_msgs = 0;
	int unsigned rejected_msgs = 0;
	int unsigned err_count = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int unsigned side_of(input logic [GRID_W-1:0] g);
		if (g == 0) return 1;
		if (g > MAX_SIZE) return MAX_SIZE;
		return g;
	endfunction

	task automatic grille_decode(input int unsigned n);
		int unsigned nn;
		int unsigned used;
		int unsigned a;
		int unsigned b;
		int unsigned r;
		logic        bad;
		plain_word_t pw;
		nn = n * n;
		used = 0;
		bad = 1'b0;
		for (int i = 0; i < CELLS; i++) pr_cov[i] = 1'b0;
		for (int turn = 0; turn < 4; turn++) begin
			for (int p = 0; p < n; p++) begin
				for (int q = 0; q < n; q++) begin
					a = p;
					b = q;
					for (int t = 0; t < turn; t++) begin
						r = n - 1 - b;
						b = a;
						a = r;
					end
					if (!bad && pr_hole[(a * n + b) % CELLS]) begin
						if (used >= nn) begin
							bad = 1'b1;
						end else begin
							pr_plain[p * n + q] = pr_cipher[used];
							pr_cov[p * n + q] = 1'b1;
							used++;
						end
					end
				end
			end
		end
		for (int i = 0; i < nn; i++) if (!pr_cov[i]) bad = 1'b1;
		if (bad) begin
			pw = '{plain: '0, last: 1'b1, invalid: 1'b1};
			plain_expect_q.push_back(pw);
			rejected_msgs++;
		end else begin
			for (int i = 0; i < nn; i++) begin
				pw = '{plain: pr_plain[i], last: (i + 1 == nn), invalid: 1'b0};
				plain_expect_q.push_back(pw);
			end
			plain_msgs++;
		end
	endtask

	task automatic grille_accept(input feed_word_t w);
		int unsigned n;
		int unsigned nn;
		n = side_of(pr_grid);
		nn = n * n;
		words_in++;
		if (w.action == ACT_CELL) begin
			if (pr_cells >= nn) pr_cells = 0;
			pr_hole[pr_cells] = w.hole;
			pr_cells++;
			pr_bytes = 0;
		end else begin
			if (pr_bytes >= nn) pr_bytes = 0;
			pr_cipher[pr_bytes] = w.cipher;
			pr_bytes++;
			if (pr_bytes == nn) begin
				pr_bytes = 0;
				grille_decode(n);
			end
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
		end else if (!drv_valid || feed_if.ready) begin
			if (pend_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				drv_valid  <= 1'b1;
				drv_action <= pend_q[0].action;
				drv_hole   <= pend_q[0].hole;
				drv_cipher <= pend_q[0].cipher;
				pend_q.pop_front();
			end else begin
				drv_valid <= 1'b0;
			end
		end
	end

	// long receiver hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_seen <= 1'b0;
			hold_left <= 0;
		end else if (hold_kick != hold_seen) begin
			hold_seen <= hold_kick;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ready <= 1'b0;
		end else begin
			rx_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) pr_grid = cfg_data;
			if (feed_if.valid && feed_if.ready) begin
				grille_accept('{action: feed_if.action, hole: feed_if.hole,
					cipher: feed_if.cipher_byte});
			end
			if (result_if.valid && result_if.ready) begin
				words_out++;
				if (plain_expect_q.size() == 0) begin
					if (err_count < 10) begin
						$display("unexpected word: plain %02h last %0b invalid %0b",
							result_if.plain_byte, result_if.last, result_if.invalid);
					end
					err_count++;
				end else if (result_if.plain_byte !== plain_expect_q[0].plain
						|| result_if.last !== plain_expect_q[0].last
						|| result_if.invalid !== plain_expect_q[0].invalid) begin
					if (err_count < 10) begin
						$display("mismatch at word %0d: exp %02h/%0b/%0b got %02h/%0b/%0b",
							words_out, plain_expect_q[0].plain, plain_expect_q[0].last,
							plain_expect_q[0].invalid, result_if.plain_byte,
							result_if.last, result_if.invalid);
					end
					err_count++;
					plain_expect_q.pop_front();
				end else begin
					plain_expect_q.pop_front();
				end
			end
		end
	end

	task automatic push_cell(input logic h);
		feed_word_t w;
		int unsigned nn;
		nn = gen_n * gen_n;
		if (gen_cells >= nn) gen_cells = 0;
		gen_written[gen_cells] = 1'b1;
		gen_cells++;
		gen_bytes = 0;
		w = '{action: ACT_CELL, hole: h, cipher: BYTE_W'($urandom)};
		pend_q.push_back(w);
		gen_items++;
	endtask

	task automatic push_byte(input logic [BYTE_W-1:0] b);
		feed_word_t w;
		int unsigned nn;
		nn = gen_n * gen_n;
		if (gen_bytes >= nn) gen_bytes = 0;
		gen_bytes++;
		if (gen_bytes == nn) gen_bytes = 0;
		w = '{action: ACT_CIPHER, hole: 1'($urandom), cipher: b};
		pend_q.push_back(w);
		gen_items++;
	endtask

	function automatic logic [BYTE_W-1:0] rand_text();
		return ($urandom_range(15) == 0) ? 8'h24 : BYTE_W'($urandom);
	endfunction

	// writes gen_grille through the cell pointer wherever it stands
	task automatic push_mask();
		int unsigned nn;
		int unsigned idx;
		nn = gen_n * gen_n;
		for (int k = 0; k < nn; k++) begin
			idx = (gen_cells >= nn) ? 0 : gen_cells;
			push_cell(gen_grille[idx]);
		end
	endtask

	task automatic make_grille(input logic well);
		int unsigned n;
		int unsigned a;
		int unsigned b;
		int unsigned r;
		n = gen_n;
		for (int i = 0; i < CELLS; i++) gen_grille[i] = well ? 1'b0 : ($urandom_range(3) == 0);
		if (well) begin
			// one hole per four-cell rotation orbit; the centre of an odd grid is set at random
			for (int p = 0; p < n / 2; p++) begin
				for (int q = 0; q < (n + 1) / 2; q++) begin
					a = p;
					b = q;
					repeat ($urandom_range(3)) begin
						r = a;
						a = b;
						b = n - 1 - r;
					end
					gen_grille[a * n + b] = 1'b1;
				end
			end
			if (n % 2 == 1) gen_grille[(n / 2) * n + n / 2] = 1'($urandom);
		end
	endtask

	function automatic logic mask_ready();
		for (int i = 0; i < gen_n * gen_n; i++) if (gen_written[i] !== 1'b1) return 1'b0;
		return 1'b1;
	endfunction

	task automatic gen_message();
		int unsigned nn;
		int unsigned kind;
		int unsigned rem;
		nn = gen_n * gen_n;
		kind = $urandom_range(7);
		if (!mask_ready() || kind < 4) begin
			make_grille(kind != 0);
			push_mask();
		end
		rem = nn - ((gen_bytes >= nn) ? 0 : gen_bytes);
		if (kind == 5 && rem > 1) begin
			// partial text dropped by a mask reload
			repeat ($urandom_range(1, rem - 1)) push_byte(rand_text());
			make_grille(1'b1);
			push_mask();
		end
		if (kind == 6) begin
			repeat ($urandom_range(1, nn)) push_cell(1'($urandom));
		end
		rem = nn - ((gen_bytes >= nn) ? 0 : gen_bytes);
		repeat (rem) push_byte(rand_text());
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pend_q.size() != 0 || drv_valid || plain_expect_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_grid(input int unsigned v);
		wait_idle();
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= GRID_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		gen_n = side_of(GRID_W'(v));
	endtask

	task automatic run_phase(input int unsigned grid, input int unsigned tx_pct,
			input int unsigned rx_pct, input int unsigned budget, input logic hold);
		int unsigned start;
		write_grid(grid);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		if (hold) hold_kick = ~hold_kick;
		start = gen_items;
		while (gen_items - start < budget) gen_message();
	endtask

	initial begin
		for (int i = 0; i < CELLS; i++) gen_written[i] = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// single cell grid: a hole overruns the text, no hole leaves it uncovered
		write_grid(0);
		push_cell(1'b1);
		push_byte(8'h00);
		push_cell(1'b0);
		push_byte(8'hFF);

		// 2x2 grid: valid grille, reuse of the mask, text dropped by a reload
		write_grid(2);
		make_grille(1'b1);
		for (int i = 0; i < CELLS; i++) gen_grille[i] = (i == 0);
		push_mask();
		push_byte(8'h00);
		push_byte(8'h24);
		push_byte(8'hFF);
		push_byte(8'h80);
		repeat (4) push_byte(rand_text());
		repeat (2) push_byte(rand_text());
		for (int i = 0; i < CELLS; i++) gen_grille[i] = (i == 1);
		push_mask();
		repeat (4) push_byte(rand_text());

		run_phase(6, 0, 0, 40, 1'b0);
		run_phase(8, 86, 0, 1, 1'b0);
		run_phase(15, 0, 86, 1, 1'b0);
		run_phase(2, 12, 12, 30, 1'b0);
		run_phase(4, 0, 0, 60, 1'b1);
		wait_idle();
		gen_message();
		run_phase(1, 0, 86, 12, 1'b0);
		run_phase(3, 12, 12, 20, 1'b0);
		run_phase(0, 86, 0, 8, 1'b0);
		run_phase(5, 0, 86, 25, 1'b0);

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("ran %0d words in and %0d words out over grid settings 0 to 15",
			words_in, words_out);
		$display("messages: %0d decrypted, %0d rejected grilles; %0d errors",
			plain_msgs, rejected_msgs, err_count);
		if (err_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#800000;
		$display("timeout with %0d words still expected", plain_expect_q.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule
